@@ rtl/teg_pkg.sv @@
// Shared types, widths and helper functions for the triangle element geometry pipeline.
// No dependencies; imported by every module of the block.
package teg_pkg;

  localparam int unsigned CoordW    = 31;
  localparam int unsigned DiffW     = 32;
  localparam int unsigned MagW      = 31;
  localparam int unsigned ShW       = 5;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;

  localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  // Sideband that travels alongside the root and quotient units.
  typedef struct packed {
    logic [63:0]           cmag;
    logic                  swapped;
    logic                  degen;
    logic [3:0][MagW-1:0]  inv_mag;
    logic [3:0]            inv_neg;
    logic                  nx_neg;
    logic                  ny_neg;
    logic [MagW-1:0]       ax_n;
    logic [MagW-1:0]       ay_n;
    logic [31:0]           root_len;
  } side_t;

  // One finished result word.
  typedef struct packed {
    logic [63:0]      jacobian_det;
    logic [3:0][31:0] inverse;
    logic [31:0]      edge_half_length;
    logic [31:0]      normal_x;
    logic [31:0]      normal_y;
    logic             nodes_swapped;
    logic             degenerate;
  } res_t;

  // Saturate a truncated inverse entry and apply its sign; a degenerate element gives zero.
  function automatic logic [31:0] inv_sat(logic [31:0] q, logic neg, logic ov, logic degen);
    logic [31:0] r;
    if (degen) begin
      r = '0;
    end else if (ov) begin
      r = neg ? SatNeg : SatPos;
    end else if (!neg) begin
      r = q[31] ? SatPos : q;
    end else begin
      r = q[31] ? SatNeg : (32'd0 - q);
    end
    return r;
  endfunction

endpackage

@@ rtl/teg_front.sv @@
// Front end of the geometry pipeline: differences, cross product, reorientation,
// edge vector, squares and normalising shift. Depends on teg_pkg.
module teg_front
  import teg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] x0_i,
  input  logic signed [CoordW-1:0] y0_i,
  input  logic signed [CoordW-1:0] x1_i,
  input  logic signed [CoordW-1:0] y1_i,
  input  logic signed [CoordW-1:0] x2_i,
  input  logic signed [CoordW-1:0] y2_i,
  input  logic [1:0]               edge_i,
  output logic                     valid_o,
  output side_t                    side_o,
  output logic [63:0]              s_len_o,
  output logic [63:0]              s_norm_o
);

  logic [8:0] valid_q;

  // stage 0: input capture
  logic signed [CoordW-1:0] x0_q [3];
  logic signed [CoordW-1:0] y0_q [3];
  logic [1:0]               e0_q;
  // stage 1: original differences
  logic signed [DiffW-1:0]  d1x_q, d1y_q, d2x_q, d2y_q;
  logic signed [CoordW-1:0] x1_q [3];
  logic signed [CoordW-1:0] y1_q [3];
  logic [1:0]               e1_q;
  // stage 2: products
  logic signed [63:0]       p1_q, p2_q;
  logic signed [CoordW-1:0] x2_q [3];
  logic signed [CoordW-1:0] y2_q [3];
  logic [1:0]               e2_q;
  // stage 3: orientation
  logic signed [CoordW-1:0] x3_q [3];
  logic signed [CoordW-1:0] y3_q [3];
  logic [1:0]               e3_q;
  logic [63:0]              cmag3_q;
  logic                     swp3_q;
  // stages 4..8
  side_t           side4_q, side5_q, side6_q, side7_q, side8_q;
  logic [MagW-1:0] ax4_q, ay4_q, ax5_q, ay5_q;
  logic [61:0]     sqx5_q, sqy5_q, sqx7_q, sqy7_q;
  logic [ShW-1:0]  sh5_q;
  logic [63:0]     slen6_q, slen7_q, slen8_q, snorm8_q;

  // combinational helpers
  logic signed [DiffW-1:0] d1x_d, d1y_d, d2x_d, d2y_d;
  logic signed [63:0]      cross_d;
  logic signed [DiffW-1:0] s1x, s1y, s2x, s2y, ex, ey;
  logic [1:0]              ia, ib;
  logic [MagW-1:0]         m_or;
  logic [ShW-1:0]          sh_d;
  side_t                   side4_d, side5_d, side6_d;

  function automatic logic signed [DiffW-1:0] sub(logic signed [CoordW-1:0] a,
                                                   logic signed [CoordW-1:0] b);
    return DiffW'(a) - DiffW'(b);
  endfunction

  function automatic logic [MagW-1:0] absv(logic signed [DiffW-1:0] v);
    logic [DiffW-1:0] t;
    t = v[DiffW-1] ? (DiffW'(0) - DiffW'(v)) : DiffW'(v);
    return t[MagW-1:0];
  endfunction

  assign d1x_d   = sub(x0_q[1], x0_q[0]);
  assign d1y_d   = sub(y0_q[1], y0_q[0]);
  assign d2x_d   = sub(x0_q[2], x0_q[0]);
  assign d2y_d   = sub(y0_q[2], y0_q[0]);
  assign cross_d = p1_q - p2_q;

  // Differences of the reoriented triangle and the chosen edge.
  always_comb begin
    s1x = sub(x3_q[1], x3_q[0]);
    s1y = sub(y3_q[1], y3_q[0]);
    s2x = sub(x3_q[2], x3_q[0]);
    s2y = sub(y3_q[2], y3_q[0]);
    unique case (e3_q)
      2'd1: begin ia = 2'd2; ib = 2'd0; end
      2'd2: begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd1; ib = 2'd2; end
    endcase
    ex = sub(x3_q[ib], x3_q[ia]);
    ey = sub(y3_q[ib], y3_q[ia]);
    side4_d          = '0;
    side4_d.cmag     = cmag3_q;
    side4_d.swapped  = swp3_q;
    side4_d.inv_mag[0] = absv(s2y);
    side4_d.inv_neg[0] = s2y[DiffW-1];
    side4_d.inv_mag[1] = absv(s2x);
    side4_d.inv_neg[1] = !s2x[DiffW-1] && (s2x != '0);
    side4_d.inv_mag[2] = absv(s1y);
    side4_d.inv_neg[2] = !s1y[DiffW-1] && (s1y != '0);
    side4_d.inv_mag[3] = absv(s1x);
    side4_d.inv_neg[3] = s1x[DiffW-1];
    side4_d.nx_neg   = ey[DiffW-1];
    side4_d.ny_neg   = !ex[DiffW-1] && (ex != '0);
  end

  // Leading-zero count of the larger magnitude: top set bit wins.
  always_comb begin
    m_or = ax4_q | ay4_q;
    sh_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (m_or[i]) sh_d = ShW'(MagW - 1 - i);
    end
  end

  // Degenerate flag, then the normalised edge magnitudes.
  always_comb begin
    side5_d       = side4_q;
    side5_d.degen = (side4_q.cmag == '0) || ((ax4_q | ay4_q) == '0);
    side6_d       = side5_q;
    side6_d.ax_n  = ax5_q << sh5_q;
    side6_d.ay_n  = ay5_q << sh5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[7:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q[0] <= x0_i; x0_q[1] <= x1_i; x0_q[2] <= x2_i;
      y0_q[0] <= y0_i; y0_q[1] <= y1_i; y0_q[2] <= y2_i;
      e0_q    <= edge_i;

      d1x_q <= d1x_d; d1y_q <= d1y_d; d2x_q <= d2x_d; d2y_q <= d2y_d;
      x1_q  <= x0_q;  y1_q  <= y0_q;  e1_q  <= e0_q;

      p1_q <= d1x_q * d2y_q;
      p2_q <= d2x_q * d1y_q;
      x2_q <= x1_q; y2_q <= y1_q; e2_q <= e1_q;

      // swap vertices 0 and 2 when the winding is clockwise
      swp3_q  <= cross_d[63];
      cmag3_q <= cross_d[63] ? (64'd0 - 64'(cross_d)) : 64'(cross_d);
      x3_q[1] <= x2_q[1];
      y3_q[1] <= y2_q[1];
      x3_q[0] <= cross_d[63] ? x2_q[2] : x2_q[0];
      y3_q[0] <= cross_d[63] ? y2_q[2] : y2_q[0];
      x3_q[2] <= cross_d[63] ? x2_q[0] : x2_q[2];
      y3_q[2] <= cross_d[63] ? y2_q[0] : y2_q[2];
      e3_q    <= e2_q;

      side4_q <= side4_d;
      ax4_q   <= absv(ex);
      ay4_q   <= absv(ey);

      side5_q <= side5_d;
      sqx5_q  <= 62'(ax4_q) * 62'(ax4_q);
      sqy5_q  <= 62'(ay4_q) * 62'(ay4_q);
      sh5_q   <= sh_d;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;

      side6_q <= side6_d;
      slen6_q <= 64'(sqx5_q) + 64'(sqy5_q);

      side7_q <= side6_q;
      sqx7_q  <= 62'(side6_q.ax_n) * 62'(side6_q.ax_n);
      sqy7_q  <= 62'(side6_q.ay_n) * 62'(side6_q.ay_n);
      slen7_q <= slen6_q;

      side8_q  <= side7_q;
      slen8_q  <= slen7_q;
      snorm8_q <= 64'(sqx7_q) + 64'(sqy7_q);
    end
  end

  assign valid_o  = valid_q[8];
  assign side_o   = side8_q;
  assign s_len_o  = slen8_q;
  assign s_norm_o = snorm8_q;

endmodule

@@ rtl/teg_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on teg_pkg.
module teg_isqrt
  import teg_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] s_i,
  output logic [31:0] root_o
);

  logic [63:0] s_q [SqrtSteps];
  logic [63:0] r_q [SqrtSteps];
  logic [63:0] s_in [SqrtSteps];
  logic [63:0] r_in [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign s_in[k] = s_i;
      assign r_in[k] = '0;
    end else begin : g_next
      assign s_in[k] = s_q[k-1];
      assign r_in[k] = r_q[k-1];
    end

    assign trial = r_in[k] + Bit;
    assign ge    = s_in[k] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k] <= ge ? (s_in[k] - trial) : s_in[k];
        r_q[k] <= ge ? ((r_in[k] >> 1) + Bit) : (r_in[k] >> 1);
      end
    end
  end

  assign root_o = r_q[SqrtSteps-1][31:0];

endmodule

@@ rtl/teg_div.sv @@
// Pipelined restoring divider: 32 quotient bits, one per register stage.
// The high part of the dividend must already be below the divisor. Depends on teg_pkg.
module teg_div
  import teg_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] hi_i,
  input  logic [31:0] lo_i,
  input  logic [63:0] den_i,
  output logic [31:0] quot_o
);

  logic [63:0] rem_q [DivSteps];
  logic [31:0] lo_q  [DivSteps];
  logic [63:0] den_q [DivSteps];
  logic [31:0] quo_q [DivSteps];
  logic [63:0] rem_in [DivSteps];
  logic [31:0] lo_in  [DivSteps];
  logic [63:0] den_in [DivSteps];
  logic [31:0] quo_in [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [64:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = hi_i;
      assign lo_in[k]  = lo_i;
      assign den_in[k] = den_i;
      assign quo_in[k] = '0;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign lo_in[k]  = lo_q[k-1];
      assign den_in[k] = den_q[k-1];
      assign quo_in[k] = quo_q[k-1];
    end

    assign t  = {rem_in[k], lo_in[k][31]};
    assign ge = t >= {1'b0, den_in[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 64'(t - {1'b0, den_in[k]}) : t[63:0];
        lo_q[k]  <= {lo_in[k][30:0], 1'b0};
        den_q[k] <= den_in[k];
        quo_q[k] <= {quo_in[k][30:0], ge};
      end
    end
  end

  assign quot_o = quo_q[DivSteps-1];

endmodule

@@ rtl/triangle_element_geometry_top.sv @@
// Straight triangle element geometry: determinant, inverse Jacobian, edge half
// length and unit outward normal. One element word is taken every clock while
// in_stall_o is low; the matching result word passes 9 set-up stages, 32
// square-root stages, 32 divider stages, one saturation stage and the output
// register. The pipeline advances as one; when a word arrives while the output
// register is stalled, a single skid register catches it and in_stall_o rises
// in the next cycle, so nothing is lost or repeated. Inputs and outputs are
// signed Q15.16 vertices, a Q32.32 determinant, Q16.16 inverse entries and a
// Q2.30 normal. Depends on teg_pkg, teg_front, teg_isqrt and teg_div.
module triangle_element_geometry_top
  import teg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] vertex0_x_i,
  input  logic signed [CoordW-1:0] vertex0_y_i,
  input  logic signed [CoordW-1:0] vertex1_x_i,
  input  logic signed [CoordW-1:0] vertex1_y_i,
  input  logic signed [CoordW-1:0] vertex2_x_i,
  input  logic signed [CoordW-1:0] vertex2_y_i,
  input  logic [1:0]               edge_select_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [63:0]       jacobian_det_o,
  output logic signed [31:0]       inverse_00_o,
  output logic signed [31:0]       inverse_01_o,
  output logic signed [31:0]       inverse_10_o,
  output logic signed [31:0]       inverse_11_o,
  output logic [31:0]              edge_half_length_o,
  output logic signed [31:0]       normal_x_o,
  output logic signed [31:0]       normal_y_o,
  output logic                     nodes_swapped_o,
  output logic                     degenerate_o
);

  logic        en;
  logic        fr_valid;
  side_t       fr_side;
  logic [63:0] fr_slen, fr_snorm;
  logic [31:0] root_len, root_norm;

  // sideband delay across the root stages and the divider stages
  side_t sa_q [SqrtSteps];
  logic  va_q [SqrtSteps];
  side_t sb_q [DivSteps];
  logic  vb_q [DivSteps];
  side_t div_side;

  logic [31:0] q_inv [4];
  logic [31:0] q_nx, q_ny;

  res_t fin_d, fin_q, out_q, skid_q;
  logic fin_valid_q, out_valid_q, skid_valid_q;
  logic take, incoming;

  // Hold the whole pipeline while the skid register is occupied.
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  teg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .x0_i     (vertex0_x_i),
    .y0_i     (vertex0_y_i),
    .x1_i     (vertex1_x_i),
    .y1_i     (vertex1_y_i),
    .x2_i     (vertex2_x_i),
    .y2_i     (vertex2_y_i),
    .edge_i   (edge_select_i),
    .valid_o  (fr_valid),
    .side_o   (fr_side),
    .s_len_o  (fr_slen),
    .s_norm_o (fr_snorm)
  );

  teg_isqrt u_sqrt_len  (.clk_i(clk_i), .en_i(en), .s_i(fr_slen),  .root_o(root_len));
  teg_isqrt u_sqrt_norm (.clk_i(clk_i), .en_i(en), .s_i(fr_snorm), .root_o(root_norm));

  always_comb begin
    div_side          = sa_q[SqrtSteps-1];
    div_side.root_len = root_len;
  end

  // Inverse entries: dividend is magnitude << 33, split as (mag << 1) and 32 zeros.
  for (genvar i = 0; i < 4; i++) begin : g_inv
    teg_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .hi_i   ({32'd0, div_side.inv_mag[i], 1'b0}),
      .lo_i   ('0),
      .den_i  (div_side.cmag),
      .quot_o (q_inv[i])
    );
  end

  // Normal components: dividend is normalised magnitude << 30.
  teg_div u_div_nx (
    .clk_i  (clk_i),
    .en_i   (en),
    .hi_i   ({35'd0, div_side.ay_n[MagW-1:2]}),
    .lo_i   ({div_side.ay_n[1:0], 30'd0}),
    .den_i  ({32'd0, root_norm}),
    .quot_o (q_nx)
  );

  teg_div u_div_ny (
    .clk_i  (clk_i),
    .en_i   (en),
    .hi_i   ({35'd0, div_side.ax_n[MagW-1:2]}),
    .lo_i   ({div_side.ax_n[1:0], 30'd0}),
    .den_i  ({32'd0, root_norm}),
    .quot_o (q_ny)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqrtSteps; k++) va_q[k] <= 1'b0;
      for (int k = 0; k < DivSteps; k++)  vb_q[k] <= 1'b0;
      fin_valid_q <= 1'b0;
    end else if (en) begin
      va_q[0] <= fr_valid;
      for (int k = 1; k < SqrtSteps; k++) va_q[k] <= va_q[k-1];
      vb_q[0] <= va_q[SqrtSteps-1];
      for (int k = 1; k < DivSteps; k++)  vb_q[k] <= vb_q[k-1];
      fin_valid_q <= vb_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0] <= fr_side;
      for (int k = 1; k < SqrtSteps; k++) sa_q[k] <= sa_q[k-1];
      sb_q[0] <= div_side;
      for (int k = 1; k < DivSteps; k++)  sb_q[k] <= sb_q[k-1];
      fin_q <= fin_d;
    end
  end

  // Saturate, apply signs, and zero the quotients of a degenerate element.
  always_comb begin
    side_t sd;
    logic  ov;
    sd = sb_q[DivSteps-1];
    fin_d = '0;
    fin_d.jacobian_det     = {2'b00, sd.cmag[63:2]};
    fin_d.edge_half_length = {1'b0, sd.root_len[31:1]};
    fin_d.nodes_swapped    = sd.swapped;
    fin_d.degenerate       = sd.degen;
    for (int i = 0; i < 4; i++) begin
      ov = {32'd0, sd.inv_mag[i], 1'b0} >= sd.cmag;
      fin_d.inverse[i] = inv_sat(q_inv[i], sd.inv_neg[i], ov, sd.degen);
    end
    fin_d.normal_x = sd.degen ? '0 : (sd.nx_neg ? (32'd0 - q_nx) : q_nx);
    fin_d.normal_y = sd.degen ? '0 : (sd.ny_neg ? (32'd0 - q_ny) : q_ny);
  end

  // Output register with a one-word skid stage behind it.
  assign take     = out_valid_q && !out_stall_i;
  assign incoming = fin_valid_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (incoming) begin
      if (!out_valid_q || take) begin
        out_q <= fin_q;
      end else begin
        skid_q <= fin_q;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign jacobian_det_o     = out_q.jacobian_det;
  assign inverse_00_o       = out_q.inverse[0];
  assign inverse_01_o       = out_q.inverse[1];
  assign inverse_10_o       = out_q.inverse[2];
  assign inverse_11_o       = out_q.inverse[3];
  assign edge_half_length_o = out_q.edge_half_length;
  assign normal_x_o         = out_q.normal_x;
  assign normal_y_o         = out_q.normal_y;
  assign nodes_swapped_o    = out_q.nodes_swapped;
  assign degenerate_o       = out_q.degenerate;

endmodule

@@ dv/teg_checker.sv @@
// Checker for the triangle element geometry block: watches both channels,
// predicts each result word from the accepted element word and compares.
// Depends on teg_pkg for the coordinate width.
module teg_checker
  import teg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [CoordW-1:0] v0x_i,
  input  logic signed [CoordW-1:0] v0y_i,
  input  logic signed [CoordW-1:0] v1x_i,
  input  logic signed [CoordW-1:0] v1y_i,
  input  logic signed [CoordW-1:0] v2x_i,
  input  logic signed [CoordW-1:0] v2y_i,
  input  logic [1:0]               edge_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [63:0]              det_i,
  input  logic [31:0]              i00_i,
  input  logic [31:0]              i01_i,
  input  logic [31:0]              i10_i,
  input  logic [31:0]              i11_i,
  input  logic [31:0]              half_len_i,
  input  logic [31:0]              nx_i,
  input  logic [31:0]              ny_i,
  input  logic                     swapped_i,
  input  logic                     degen_i,
  output int                       errors_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [63:0] det;
    logic [31:0] i00, i01, i10, i11, half_len, nx, ny;
    logic        swapped, degen;
  } geom_t;

  geom_t geom_q[$];

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] inv_of(logic signed [63:0] num, logic [63:0] cm);
    logic [127:0] q;
    q = {64'd0, mag(num)} << 33;
    q = q / cm;
    if (num >= 0) return q > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
    if (q >= 128'h8000_0000) return 32'h8000_0000;
    return 32'd0 - q[31:0];
  endfunction

  function automatic geom_t predict_geom(logic signed [63:0] px[3], logic signed [63:0] py[3],
                                         logic [1:0] e);
    geom_t g;
    logic signed [63:0] d1x, d1y, d2x, d2y, cr, ex, ey, t;
    logic [63:0] cm, s, ax, ay, r, q, hl;
    int a, b;
    cr = (px[1] - px[0]) * (py[2] - py[0]) - (px[2] - px[0]) * (py[1] - py[0]);
    g = '0;
    g.swapped = cr < 0;
    if (g.swapped) begin
      t = px[0]; px[0] = px[2]; px[2] = t;
      t = py[0]; py[0] = py[2]; py[2] = t;
    end
    d1x = px[1] - px[0]; d1y = py[1] - py[0];
    d2x = px[2] - px[0]; d2y = py[2] - py[0];
    cm = mag(d1x * d2y - d2x * d1y);
    a = (e + 1) % 3;
    b = (e + 2) % 3;
    ex = px[b] - px[a];
    ey = py[b] - py[a];
    ax = mag(ex);
    ay = mag(ey);
    s = ax * ax + ay * ay;
    g.degen = (cm == 0) || (s == 0);
    if (!g.degen) begin
      g.i00 = inv_of(d2y, cm);
      g.i01 = inv_of(-d2x, cm);
      g.i10 = inv_of(-d1y, cm);
      g.i11 = inv_of(d1x, cm);
      while (((ax | ay) >> 30) == 0) begin
        ax = ax << 1;
        ay = ay << 1;
      end
      r = root64(ax * ax + ay * ay);
      q = (ay << 30) / r;
      g.nx = ey < 0 ? 32'd0 - q[31:0] : q[31:0];
      q = (ax << 30) / r;
      g.ny = ex > 0 ? 32'd0 - q[31:0] : q[31:0];
    end
    g.det = cm >> 2;
    hl = root64(s) >> 1;
    g.half_len = hl[31:0];
    return g;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    errors_o++;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i) begin
    logic signed [63:0] px[3], py[3];
    geom_t w;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      px[0] = 64'(v0x_i); py[0] = 64'(v0y_i);
      px[1] = 64'(v1x_i); py[1] = 64'(v1y_i);
      px[2] = 64'(v2x_i); py[2] = 64'(v2y_i);
      geom_q = {geom_q, predict_geom(px, py, edge_i)};
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (geom_q.size() == 0) begin
        report_mismatch("unexpected word", 64'd0, 64'd0);
      end else begin
        w = geom_q.pop_front();
        if (det_i !== w.det) report_mismatch("jacobian_det", det_i, w.det);
        if (i00_i !== w.i00) report_mismatch("inverse_00", 64'(i00_i), 64'(w.i00));
        if (i01_i !== w.i01) report_mismatch("inverse_01", 64'(i01_i), 64'(w.i01));
        if (i10_i !== w.i10) report_mismatch("inverse_10", 64'(i10_i), 64'(w.i10));
        if (i11_i !== w.i11) report_mismatch("inverse_11", 64'(i11_i), 64'(w.i11));
        if (half_len_i !== w.half_len)
          report_mismatch("edge_half_length", 64'(half_len_i), 64'(w.half_len));
        if (nx_i !== w.nx) report_mismatch("normal_x", 64'(nx_i), 64'(w.nx));
        if (ny_i !== w.ny) report_mismatch("normal_y", 64'(ny_i), 64'(w.ny));
        if (swapped_i !== w.swapped)
          report_mismatch("nodes_swapped", 64'(swapped_i), 64'(w.swapped));
        if (degen_i !== w.degen) report_mismatch("degenerate", 64'(degen_i), 64'(w.degen));
      end
    end
    pending_o = geom_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the triangle element geometry testbench: clock, reset, element
// stimulus, output stalls, watchdog and verdict. Depends on teg_pkg,
// teg_checker and the block's top level.
module testbench;
  import teg_pkg::*;

  localparam int RandWords = 1850;
  localparam int CalmWords = 200;    // final stretch without idling
  localparam int Latency   = 75;
  localparam int Watchdog  = 2000;
  localparam logic signed [CoordW-1:0] CMax = 31'sh3FFF_FFFF;
  localparam logic signed [CoordW-1:0] CMin = 31'sh4000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic signed [CoordW-1:0] v0x = '0, v0y = '0, v1x = '0, v1y = '0, v2x = '0, v2y = '0;
  logic [1:0] edge_sel = '0;
  logic signed [63:0] det;
  logic signed [31:0] i00, i01, i10, i11, nx, ny;
  logic [31:0] half_len;
  logic swapped, degen;
  int errors, pending;
  int idle_cnt = 0;
  bit calm = 1'b0;

  // Flip the clock every 2 time units.
  always #2 clk = ~clk;

  triangle_element_geometry_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vertex0_x_i(v0x), .vertex0_y_i(v0y), .vertex1_x_i(v1x), .vertex1_y_i(v1y),
    .vertex2_x_i(v2x), .vertex2_y_i(v2y), .edge_select_i(edge_sel),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .jacobian_det_o(det), .inverse_00_o(i00), .inverse_01_o(i01),
    .inverse_10_o(i10), .inverse_11_o(i11), .edge_half_length_o(half_len),
    .normal_x_o(nx), .normal_y_o(ny), .nodes_swapped_o(swapped), .degenerate_o(degen)
  );

  teg_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .v0x_i(v0x), .v0y_i(v0y), .v1x_i(v1x), .v1y_i(v1y), .v2x_i(v2x), .v2y_i(v2y),
    .edge_i(edge_sel),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .det_i(det), .i00_i(i00), .i01_i(i01), .i10_i(i10), .i11_i(i11),
    .half_len_i(half_len), .nx_i(nx), .ny_i(ny), .swapped_i(swapped), .degen_i(degen),
    .errors_o(errors), .pending_o(pending)
  );

  // Stall the output side in random bursts, except in the calm stretch.
  always @(posedge clk) begin
    int burst;
    if (calm) begin
      out_stall <= 1'b0;
    end else if (idle_cnt > 0) begin
      idle_cnt <= idle_cnt - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 9);
      idle_cnt <= burst - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= Watchdog) begin
      $display("[triangle_element_geometry_top] ERROR");
      $finish;
    end
  end

  // Random coordinate: mostly small, sometimes anywhere, sometimes an extreme.
  function automatic logic signed [CoordW-1:0] rand_coord();
    unique case ($urandom_range(0, 7))
      0: return CMax;
      1: return CMin;
      2, 3: return CoordW'($urandom);
      default: return CoordW'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  // Present one element word and hold it until accepted.
  task automatic send_element(logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy,
                              logic [1:0] e);
    v0x <= ax; v0y <= ay; v1x <= bx; v1y <= by; v2x <= cx; v2y <= cy;
    edge_sel <= e;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid for a random burst of cycles.
  task automatic idle_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  initial begin
    logic signed [CoordW-1:0] c[6];
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unit triangles both orientations, every edge number incl. three,
    // collinear and coincident vertices, extremes, a tiny huge-inverse element.
    for (int e = 0; e < 4; e++) begin
      send_element(0, 0, 31'sh10000, 0, 0, 31'sh10000, 2'(e));
      send_element(0, 0, 0, 31'sh10000, 31'sh10000, 0, 2'(e));
    end
    send_element(0, 0, 31'sh10000, 31'sh10000, 31'sh20000, 31'sh20000, 0);
    send_element(5, 5, 5, 5, 5, 5, 1);
    send_element(5, 5, 5, 5, 31'sh10000, 7, 0);
    send_element(5, 5, 5, 5, 31'sh10000, 7, 1);
    send_element(CMin, CMin, CMax, CMin, CMin, CMax, 0);
    send_element(CMin, CMin, CMin, CMax, CMax, CMin, 2);
    send_element(CMax, CMax, CMin, CMax, CMax, CMin, 1);
    send_element(CMin, CMax, CMax, CMin, CMax, CMax, 3);
    send_element(0, 0, 1, 0, 0, 1, 0);
    send_element(0, 0, 1, 0, 0, 1, 2);
    send_element(0, 0, CMax, 1, 1, CMax, 1);
    send_element(-1, -1, CMax, CMin, CMin, CMax, 0);
    in_valid <= 1'b0;

    // Hold off until every expected word has come back.
    while (pending != 0) @(posedge clk);

    n = 0;
    while (n < RandWords) begin
      if (!calm && $urandom_range(0, 7) == 0) idle_sender();
      for (int k = 0; k < 6; k++) c[k] = rand_coord();
      if ($urandom_range(0, 15) == 0) begin
        c[2] = c[0]; c[3] = c[1];   // coincident pair
      end
      send_element(c[0], c[1], c[2], c[3], c[4], c[5], 2'($urandom_range(0, 3)));
      n++;
      if (n == RandWords - CalmWords) calm = 1'b1;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0) $display("[triangle_element_geometry_top] OK");
    else $display("[triangle_element_geometry_top] ERROR");
    $finish;
  end

endmodule

@@ triangle_element_geometry_top.f @@
rtl/teg_pkg.sv
rtl/teg_front.sv
rtl/teg_isqrt.sv
rtl/teg_div.sv
rtl/triangle_element_geometry_top.sv
dv/teg_checker.sv
dv/testbench.sv
